// ----- rtl/fccp_pkg.sv -----
// shared types and constants of the freshness count cache policy
`default_nettype none

package fccp_pkg;

   localparam int KEY_IN_BITS    = 8;
   localparam int FRESH_BITS     = 8;
   localparam int OUT_COUNT_BITS = 32;
   localparam int DISTINCT_BITS  = 9;

   localparam logic [DISTINCT_BITS-1:0] DISTINCT_MAX = 9'd511;

   typedef enum logic [1:0] {
      REQ_ACCESS     = 2'd0,
      REQ_MARK_FRESH = 2'd1,
      REQ_PURGE      = 2'd2,
      REQ_QUERY      = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic                  text_valid;
      logic                  binary_valid;
      logic [FRESH_BITS-1:0] text_fresh;
      logic [FRESH_BITS-1:0] binary_fresh;
   } slot_type;

   typedef struct packed {
      logic write;
      logic purge;
   } table_ctl_type;

   typedef struct packed {
      logic update;
      logic reload;
      logic first_touch;
   } stats_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/fccp_channels.sv -----
// valid/ready channel interfaces for requests, responses and the csr write
`default_nettype none

interface fccp_req_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         req_type;
   logic [fccp_pkg::KEY_IN_BITS-1:0]   key;
   logic                               is_binary;

   modport source (output valid, req_type, key, is_binary, input ready);
   modport sink   (input valid, req_type, key, is_binary, output ready);
endinterface

interface fccp_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 hit;
   logic                                 cached;
   logic [fccp_pkg::FRESH_BITS-1:0]      freshness;
   logic [fccp_pkg::OUT_COUNT_BITS-1:0]  key_requests;
   logic [fccp_pkg::KEY_IN_BITS-1:0]     top_key;
   logic [fccp_pkg::OUT_COUNT_BITS-1:0]  top_requests;
   logic [fccp_pkg::OUT_COUNT_BITS-1:0]  total_requests;
   logic [fccp_pkg::DISTINCT_BITS-1:0]   files_requested;
   logic [fccp_pkg::OUT_COUNT_BITS-1:0]  disk_reads;

   modport source (output valid, hit, cached, freshness, key_requests, top_key, top_requests,
                   total_requests, files_requested, disk_reads, input ready);
   modport sink   (input valid, hit, cached, freshness, key_requests, top_key, top_requests,
                   total_requests, files_requested, disk_reads, output ready);
endinterface

interface fccp_csr_if;
   logic                             valid;
   logic                             ready;
   logic [fccp_pkg::FRESH_BITS-1:0]  fresh_limit;

   modport source (output valid, fresh_limit, input ready);
   modport sink   (input valid, fresh_limit, output ready);
endinterface

`default_nettype wire

// ----- rtl/freshness_count_cache_policy.sv -----
// top level of the freshness count cache policy
// a request passes the input register and then the result register before its response is valid
// throughput: one transaction per cycle while responses are taken, set by the read-modify-write
// of the slot ram with forwarding of the previous write
// reset: synchronous; clears valid and seen bits, counters, top key and fresh_limit at once,
// no clearing pass, ready as soon as reset is released
`default_nettype none

module freshness_count_cache_policy #(
   parameter int KEYS = 256,
   parameter int COUNT_BITS = 32
) (
   input  wire logic     clock,
   input  wire logic     reset,
   fccp_req_if.sink      req,
   fccp_rsp_if.source    rsp,
   fccp_csr_if.sink      csr
);

   localparam int KEY_BITS = $clog2(KEYS);
   localparam int FB       = fccp_pkg::FRESH_BITS;
   localparam int OB       = fccp_pkg::OUT_COUNT_BITS;
   localparam int KB       = fccp_pkg::KEY_IN_BITS;
   localparam int DB       = fccp_pkg::DISTINCT_BITS;

   logic          fresh_limit_ff;
   logic [FB-1:0] limit_ff;

   logic          s1_valid_ff, s1_valid_in;
   logic [1:0]    s1_req_type_ff;
   logic [KB-1:0] s1_key_ff;
   logic          s1_binary_ff;
   logic          req_accept;
   logic          s1_advance;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_hit_ff;
   logic          rsp_cached_ff;
   logic [FB-1:0] rsp_freshness_ff;
   logic [OB-1:0] rsp_key_requests_ff;
   logic [KB-1:0] rsp_top_key_ff;
   logic [OB-1:0] rsp_top_requests_ff;
   logic [OB-1:0] rsp_total_requests_ff;
   logic [DB-1:0] rsp_files_requested_ff;
   logic [OB-1:0] rsp_disk_reads_ff;

   fccp_pkg::req_kind_type  kind;
   fccp_pkg::slot_type      cur_slot;
   fccp_pkg::slot_type      new_slot;
   fccp_pkg::table_ctl_type table_ctl;
   fccp_pkg::stats_ctl_type stats_ctl;
   logic [KEY_BITS-1:0]     rd_key;
   logic [KEY_BITS-1:0]     cur_key;
   logic [COUNT_BITS-1:0]   cur_count;
   logic [COUNT_BITS-1:0]   new_count;
   logic                    in_range;
   logic                    is_access;
   logic                    is_mark;
   logic                    is_purge;
   logic                    sel_valid;
   logic [FB-1:0]           sel_fresh;
   logic [FB-1:0]           reload_fresh;
   logic                    hit;
   logic                    cached;
   logic [FB-1:0]           freshness;
   logic [OB-1:0]           key_requests;
   logic [KEY_BITS-1:0]     top_index;
   logic [COUNT_BITS-1:0]   top_count;
   logic [COUNT_BITS-1:0]   total;
   logic [DB-1:0]           distinct;
   logic [COUNT_BITS-1:0]   reloads;

   // configuration register
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_limit_ff <= 1'b0;
         limit_ff       <= '0;
      end else if (csr.valid) begin
         fresh_limit_ff <= 1'b1;
         limit_ff       <= csr.fresh_limit;
      end
   end

   // input register
   assign req_accept = req.valid && req.ready;
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready  = !s1_valid_ff || s1_advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_type_ff <= req.req_type;
         s1_key_ff      <= req.key;
         s1_binary_ff   <= req.is_binary;
      end
   end

   // slot read is issued with the transaction so the row lines up with the input register
   assign rd_key  = KEY_BITS'(32'(req.key));
   assign cur_key = KEY_BITS'(32'(s1_key_ff));

   fccp_table #(
      .KEYS       (KEYS),
      .COUNT_BITS (COUNT_BITS)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_accept),
      .rd_key    (rd_key),
      .cur_key   (cur_key),
      .ctl       (table_ctl),
      .new_slot  (new_slot),
      .new_count (new_count),
      .cur_slot  (cur_slot),
      .cur_count (cur_count)
   );

   // one step of the policy
   always_comb begin
      kind      = fccp_pkg::req_kind_type'(s1_req_type_ff);
      in_range  = 32'(s1_key_ff) < 32'(KEYS);
      is_access = 1'b0;
      is_mark   = 1'b0;
      is_purge  = 1'b0;
      unique case (kind)
         fccp_pkg::REQ_ACCESS:     is_access = in_range;
         fccp_pkg::REQ_MARK_FRESH: is_mark   = in_range;
         fccp_pkg::REQ_PURGE:      is_purge  = 1'b1;
         fccp_pkg::REQ_QUERY:      is_purge  = 1'b0;
         default:                  is_purge  = 1'b0;
      endcase

      sel_valid    = s1_binary_ff ? cur_slot.binary_valid : cur_slot.text_valid;
      sel_fresh    = s1_binary_ff ? cur_slot.binary_fresh : cur_slot.text_fresh;
      reload_fresh = (limit_ff != '0) ? limit_ff - 1'b1 : '0;
      hit = is_access && (limit_ff > 8'd1) && sel_valid && (sel_fresh != '0);

      new_slot  = cur_slot;
      new_count = cur_count;
      if (is_access) begin
         if (s1_binary_ff) begin
            new_slot.binary_valid = 1'b1;
            new_slot.binary_fresh = hit ? sel_fresh - 1'b1 : reload_fresh;
         end else begin
            new_slot.text_valid = 1'b1;
            new_slot.text_fresh = hit ? sel_fresh - 1'b1 : reload_fresh;
         end
         if (cur_count != '1) begin
            new_count = cur_count + 1'b1;
         end
      end else if (is_mark) begin
         if (cur_slot.text_valid) begin
            new_slot.text_fresh = limit_ff;
         end else if (cur_slot.binary_valid) begin
            new_slot.binary_fresh = limit_ff;
         end
      end else if (is_purge) begin
         new_slot.text_valid   = 1'b0;
         new_slot.binary_valid = 1'b0;
      end

      cached       = 1'b0;
      freshness    = '0;
      key_requests = '0;
      if (in_range) begin
         cached       = new_slot.text_valid || new_slot.binary_valid;
         key_requests = OB'(new_count);
         if (limit_ff != '0) begin
            if (new_slot.text_valid) begin
               freshness = new_slot.text_fresh;
            end else if (new_slot.binary_valid) begin
               freshness = new_slot.binary_fresh;
            end
         end
      end

      table_ctl.write       = s1_advance && (is_access || is_mark);
      table_ctl.purge       = s1_advance && is_purge;
      stats_ctl.update      = s1_advance && is_access;
      stats_ctl.reload      = !hit;
      stats_ctl.first_touch = (cur_count == '0);
   end

   fccp_stats #(
      .KEYS       (KEYS),
      .COUNT_BITS (COUNT_BITS)
   ) u_stats (
      .clock     (clock),
      .reset     (reset),
      .ctl       (stats_ctl),
      .key_idx   (cur_key),
      .key_count (new_count),
      .top_index (top_index),
      .top_count (top_count),
      .total     (total),
      .distinct  (distinct),
      .reloads   (reloads)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_hit_ff             <= hit;
         rsp_cached_ff          <= cached;
         rsp_freshness_ff       <= freshness;
         rsp_key_requests_ff    <= key_requests;
         rsp_top_key_ff         <= KB'(top_index);
         rsp_top_requests_ff    <= OB'(top_count);
         rsp_total_requests_ff  <= OB'(total);
         rsp_files_requested_ff <= distinct;
         rsp_disk_reads_ff      <= OB'(reloads);
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.hit             = rsp_hit_ff;
   assign rsp.cached          = rsp_cached_ff;
   assign rsp.freshness       = rsp_freshness_ff;
   assign rsp.key_requests    = rsp_key_requests_ff;
   assign rsp.top_key         = rsp_top_key_ff;
   assign rsp.top_requests    = rsp_top_requests_ff;
   assign rsp.total_requests  = rsp_total_requests_ff;
   assign rsp.files_requested = rsp_files_requested_ff;
   assign rsp.disk_reads      = rsp_disk_reads_ff;

`ifndef SYNTH
   // a hit is served from a valid slot, so the key must show as cached
   hit_implies_cached: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.hit) |-> rsp.cached)
      else $error("hit reported for a key that is not cached");

   distinct_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (32'(rsp.files_requested) <= KEYS))
      else $error("more distinct keys than the table holds");

   advance_fills_result: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_valid_ff)
      else $error("transaction left the input register without a result");

   limit_seen_before_hit: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && hit) |-> fresh_limit_ff)
      else $error("hit while fresh_limit was never written");
`endif

endmodule

`default_nettype wire

// ----- rtl/fccp_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none

module fccp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/fccp_table.sv -----
// per-key slot table: valid and seen flops, fresh/count ram with write forwarding
`default_nettype none

module fccp_table #(
   parameter int KEYS = 256,
   parameter int COUNT_BITS = 32,
   localparam int KEY_BITS = $clog2(KEYS)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     rd_en,
   input  wire logic [KEY_BITS-1:0]      rd_key,
   input  wire logic [KEY_BITS-1:0]      cur_key,
   input  wire fccp_pkg::table_ctl_type  ctl,
   input  wire fccp_pkg::slot_type       new_slot,
   input  wire logic [COUNT_BITS-1:0]    new_count,
   output fccp_pkg::slot_type            cur_slot,
   output logic      [COUNT_BITS-1:0]    cur_count
);

   localparam int FB = fccp_pkg::FRESH_BITS;
   localparam int ROW_BITS = 2 * FB + COUNT_BITS;

   logic [KEYS-1:0]     text_valid_ff;
   logic [KEYS-1:0]     binary_valid_ff;
   logic [KEYS-1:0]     seen_ff;
   logic                fwd_valid_ff;
   logic [KEY_BITS-1:0] fwd_key_ff;
   logic [ROW_BITS-1:0] fwd_row_ff;
   logic [ROW_BITS-1:0] ram_rd_data;
   logic [ROW_BITS-1:0] wr_row;
   logic [ROW_BITS-1:0] row;

   assign wr_row = {new_count, new_slot.text_fresh, new_slot.binary_fresh};

   fccp_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (KEYS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctl.write),
      .wr_addr (cur_key),
      .wr_data (wr_row),
      .rd_en   (rd_en),
      .rd_addr (rd_key),
      .rd_data (ram_rd_data)
   );

   // the ram read may have passed the previous transaction's write to the same key
   assign row = (fwd_valid_ff && (fwd_key_ff == cur_key)) ? fwd_row_ff : ram_rd_data;

   always_comb begin
      cur_slot.text_valid   = text_valid_ff[cur_key];
      cur_slot.binary_valid = binary_valid_ff[cur_key];
      cur_slot.text_fresh   = row[2*FB-1:FB];
      cur_slot.binary_fresh = row[FB-1:0];
      // never-accessed keys read a zero count whatever the ram holds
      cur_count = seen_ff[cur_key] ? row[ROW_BITS-1:2*FB] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_valid_ff   <= '0;
         binary_valid_ff <= '0;
         seen_ff         <= '0;
         fwd_valid_ff    <= 1'b0;
      end else begin
         if (ctl.purge) begin
            text_valid_ff   <= '0;
            binary_valid_ff <= '0;
         end else if (ctl.write) begin
            text_valid_ff[cur_key]   <= new_slot.text_valid;
            binary_valid_ff[cur_key] <= new_slot.binary_valid;
         end
         if (ctl.write) begin
            seen_ff[cur_key] <= seen_ff[cur_key] | (new_count != '0);
            fwd_valid_ff     <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.write) begin
         fwd_key_ff <= cur_key;
         fwd_row_ff <= wr_row;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/fccp_stats.sv -----
// global counters and incremental top key tracking
`default_nettype none

module fccp_stats #(
   parameter int KEYS = 256,
   parameter int COUNT_BITS = 32,
   localparam int KEY_BITS = $clog2(KEYS)
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire fccp_pkg::stats_ctl_type              ctl,
   input  wire logic [KEY_BITS-1:0]                  key_idx,
   input  wire logic [COUNT_BITS-1:0]                key_count,
   output logic      [KEY_BITS-1:0]                  top_index,
   output logic      [COUNT_BITS-1:0]                top_count,
   output logic      [COUNT_BITS-1:0]                total,
   output logic      [fccp_pkg::DISTINCT_BITS-1:0]   distinct,
   output logic      [COUNT_BITS-1:0]                reloads
);

   logic [KEY_BITS-1:0]                top_index_ff, top_index_in;
   logic [COUNT_BITS-1:0]              top_count_ff, top_count_in;
   logic [COUNT_BITS-1:0]              total_ff, total_in;
   logic [fccp_pkg::DISTINCT_BITS-1:0] distinct_ff, distinct_in;
   logic [COUNT_BITS-1:0]              reloads_ff, reloads_in;

   always_comb begin
      top_index_in = top_index_ff;
      top_count_in = top_count_ff;
      total_in     = total_ff;
      distinct_in  = distinct_ff;
      reloads_in   = reloads_ff;
      if (ctl.update) begin
         // ties go to the lower key
         if ((key_count > top_count_ff) ||
             ((key_count == top_count_ff) && (key_idx < top_index_ff))) begin
            top_index_in = key_idx;
            top_count_in = key_count;
         end
         if (total_ff != '1) begin
            total_in = total_ff + 1'b1;
         end
         if (ctl.reload && (reloads_ff != '1)) begin
            reloads_in = reloads_ff + 1'b1;
         end
         if (ctl.first_touch && (distinct_ff != fccp_pkg::DISTINCT_MAX)) begin
            distinct_in = distinct_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_index_ff <= '0;
         top_count_ff <= '0;
         total_ff     <= '0;
         distinct_ff  <= '0;
         reloads_ff   <= '0;
      end else begin
         top_index_ff <= top_index_in;
         top_count_ff <= top_count_in;
         total_ff     <= total_in;
         distinct_ff  <= distinct_in;
         reloads_ff   <= reloads_in;
      end
   end

   // values after the current transaction's step
   assign top_index = top_index_in;
   assign top_count = top_count_in;
   assign total     = total_in;
   assign distinct  = distinct_in;
   assign reloads   = reloads_in;

endmodule

`default_nettype wire
